// ===== rtl/core/axis_angle_rotation_matrix_assert.svh =====
// assertion macros for the rotation matrix block
`ifndef AXIS_ANGLE_ROTATION_MATRIX_ASSERT_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_ASSERT_SVH

// same-cycle implication, off while in reset
`define AARM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aarm check failed");

// next-cycle implication, off while in reset
`define AARM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aarm check failed");

// next-cycle implication, also checked through reset
`define AARM_ASSERT_NEXT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("aarm check failed");

`endif

// ===== rtl/core/aarm_pkg.sv =====
`timescale 1ns / 1ps
package aarm_pkg;

    localparam int CORDIC_STAGES = 14;
    localparam int TABLE_LEN     = 24;
    localparam int N_STAGES      = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int SH_W          = 5;

    localparam int A_W  = 15;
    localparam int U_W  = 16;
    localparam int XY_W = 33;
    localparam int Z_W  = 32;
    localparam int UU_W = 32;
    localparam int P_W  = 65;
    localparam int US_W = 49;
    localparam int S_W  = 66;
    localparam int O_W  = 16;
    localparam int N_OUT = 9;

    typedef logic signed [A_W-1:0]  t_angle;
    typedef logic signed [U_W-1:0]  t_u;
    typedef logic signed [XY_W-1:0] t_xy;
    typedef logic signed [Z_W-1:0]  t_z;
    typedef logic signed [UU_W-1:0] t_uu;
    typedef logic signed [P_W-1:0]  t_p;
    typedef logic signed [US_W-1:0] t_us;
    typedef logic signed [S_W-1:0]  t_sum;
    typedef logic signed [O_W-1:0]  t_o;

    localparam t_xy CORDIC_K = 33'sd652032874;
    localparam t_xy ONE_Q30  = 33'sd1073741824;
    localparam t_z  PI_Q28   = 32'sd843314857;
    localparam t_z  HALF_PI  = 32'sd421657428;
    localparam t_sum ROUND_HALF = 66'sd8796093022208;
    localparam t_sum OUT_MAX = 66'sd16384;

    localparam t_z ATAN_Q28 [TABLE_LEN] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32
    };

    typedef struct packed {
        t_xy  x;
        t_xy  y;
        t_z   z;
        logic flip;
        t_u   ux;
        t_u   uy;
        t_u   uz;
    } t_cordic;

    typedef struct packed {
        t_xy c;
        t_us sx;
        t_us sy;
        t_us sz;
        t_p  pxx;
        t_p  pyy;
        t_p  pzz;
        t_p  pxy;
        t_p  pxz;
        t_p  pyz;
    } t_prod;

    // round half up from q.58 to q.14, then clamp to plus or minus one
    function automatic t_o round_sat(input t_sum v);
        t_sum r;
        r = (v + ROUND_HALF) >>> 44;
        if (r > OUT_MAX) begin
            r = OUT_MAX;
        end else if (r < -OUT_MAX) begin
            r = -OUT_MAX;
        end
        return t_o'(r);
    endfunction

endpackage

// ===== rtl/core/aarm_prep.sv =====
`timescale 1ns / 1ps
module aarm_prep (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  aarm_pkg::t_angle i_angle,
    input  aarm_pkg::t_u     i_axis_x,
    input  aarm_pkg::t_u     i_axis_y,
    input  aarm_pkg::t_u     i_axis_z,
    output logic             o_valid,
    input  logic             i_ready,
    output aarm_pkg::t_cordic o_data
);
    import aarm_pkg::*;

    logic    r_valid;
    t_cordic r_data;
    t_cordic n_data;
    t_z      z_in;

    // fold the angle into plus or minus half pi
    always_comb begin
        z_in          = t_z'(i_angle) <<< 16;
        n_data.x      = CORDIC_K;
        n_data.y      = '0;
        n_data.ux     = i_axis_x;
        n_data.uy     = i_axis_y;
        n_data.uz     = i_axis_z;
        n_data.flip   = 1'b0;
        n_data.z      = z_in;
        if (z_in > HALF_PI) begin
            n_data.z    = z_in - PI_Q28;
            n_data.flip = 1'b1;
        end else if (z_in < -HALF_PI) begin
            n_data.z    = z_in + PI_Q28;
            n_data.flip = 1'b1;
        end
    end

    assign o_ready = !r_valid || i_ready;

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ===== rtl/core/aarm_cordic_stage.sv =====
`timescale 1ns / 1ps
module aarm_cordic_stage (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [aarm_pkg::SH_W-1:0] i_shift,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  aarm_pkg::t_cordic         i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output aarm_pkg::t_cordic         o_data
);
    import aarm_pkg::*;

    logic    r_valid;
    t_cordic r_data;
    t_cordic n_data;
    t_xy     dx;
    t_xy     dy;

    // one micro-rotation toward zero residual angle
    always_comb begin
        dx     = i_data.x >>> i_shift;
        dy     = i_data.y >>> i_shift;
        n_data = i_data;
        if (!i_data.z[Z_W-1]) begin
            n_data.x = i_data.x - dy;
            n_data.y = i_data.y + dx;
            n_data.z = i_data.z - ATAN_Q28[i_shift];
        end else begin
            n_data.x = i_data.x + dy;
            n_data.y = i_data.y - dx;
            n_data.z = i_data.z + ATAN_Q28[i_shift];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ===== rtl/core/aarm_mult.sv =====
`timescale 1ns / 1ps
module aarm_mult (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  aarm_pkg::t_cordic i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output aarm_pkg::t_prod   o_data
);
    import aarm_pkg::*;

    logic  r_a_valid;
    t_xy   r_c;
    t_xy   r_s;
    t_xy   r_t;
    t_u    r_ux;
    t_u    r_uy;
    t_u    r_uz;
    t_uu   r_uxx;
    t_uu   r_uyy;
    t_uu   r_uzz;
    t_uu   r_uxy;
    t_uu   r_uxz;
    t_uu   r_uyz;
    t_xy   n_c;
    t_xy   n_s;
    logic  a_ready;

    logic  r_b_valid;
    t_prod r_prod;
    t_prod n_prod;

    // undo the half-turn fold, form t = 1 - c
    always_comb begin
        n_c = i_data.flip ? -i_data.x : i_data.x;
        n_s = i_data.flip ? -i_data.y : i_data.y;
    end

    assign o_ready = !r_a_valid || a_ready;
    assign a_ready = !r_b_valid || i_ready;

    // first stage: trig terms and axis products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_c   <= n_c;
            r_s   <= n_s;
            r_t   <= ONE_Q30 - n_c;
            r_ux  <= i_data.ux;
            r_uy  <= i_data.uy;
            r_uz  <= i_data.uz;
            r_uxx <= t_uu'(i_data.ux * i_data.ux);
            r_uyy <= t_uu'(i_data.uy * i_data.uy);
            r_uzz <= t_uu'(i_data.uz * i_data.uz);
            r_uxy <= t_uu'(i_data.ux * i_data.uy);
            r_uxz <= t_uu'(i_data.ux * i_data.uz);
            r_uyz <= t_uu'(i_data.uy * i_data.uz);
        end
    end

    // second stage: scale by t and s
    always_comb begin
        n_prod.c   = r_c;
        n_prod.sx  = t_us'(r_ux) * t_us'(r_s);
        n_prod.sy  = t_us'(r_uy) * t_us'(r_s);
        n_prod.sz  = t_us'(r_uz) * t_us'(r_s);
        n_prod.pxx = t_p'(r_uxx) * t_p'(r_t);
        n_prod.pyy = t_p'(r_uyy) * t_p'(r_t);
        n_prod.pzz = t_p'(r_uzz) * t_p'(r_t);
        n_prod.pxy = t_p'(r_uxy) * t_p'(r_t);
        n_prod.pxz = t_p'(r_uxz) * t_p'(r_t);
        n_prod.pyz = t_p'(r_uyz) * t_p'(r_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && r_a_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_prod;
endmodule

// ===== rtl/core/aarm_round.sv =====
`timescale 1ns / 1ps
module aarm_round (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  aarm_pkg::t_prod i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output aarm_pkg::t_o    o_r [aarm_pkg::N_OUT]
);
    import aarm_pkg::*;

    logic r_valid;
    t_o   r_r [N_OUT];
    t_o   n_r [N_OUT];
    t_sum c58;
    t_sum sx;
    t_sum sy;
    t_sum sz;

    // sum each entry in q.58, then round and clamp
    always_comb begin
        c58    = t_sum'(i_data.c) <<< 28;
        sx     = t_sum'(i_data.sx) <<< 14;
        sy     = t_sum'(i_data.sy) <<< 14;
        sz     = t_sum'(i_data.sz) <<< 14;
        n_r[0] = round_sat(c58 + t_sum'(i_data.pxx));
        n_r[1] = round_sat(t_sum'(i_data.pxy) - sz);
        n_r[2] = round_sat(t_sum'(i_data.pxz) + sy);
        n_r[3] = round_sat(t_sum'(i_data.pxy) + sz);
        n_r[4] = round_sat(c58 + t_sum'(i_data.pyy));
        n_r[5] = round_sat(t_sum'(i_data.pyz) - sx);
        n_r[6] = round_sat(t_sum'(i_data.pxz) - sy);
        n_r[7] = round_sat(t_sum'(i_data.pyz) + sx);
        n_r[8] = round_sat(c58 + t_sum'(i_data.pzz));
    end

    assign o_ready = !r_valid || !i_stall;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_r <= n_r;
        end
    end

    assign o_valid = r_valid;
    assign o_r     = r_r;
endmodule

// ===== rtl/core/axis_angle_rotation_matrix.sv =====
`timescale 1ns / 1ps
// axis-angle to 3x3 rotation matrix (rodrigues), fixed point
// input channel: i_valid / o_stall carry one item of angle (q2.12 rad)
//   and axis x, y, z (q1.14, assumed unit length, not normalized)
// output channel: o_valid / i_stall carry the nine entries r00..r22 in
//   q1.14, rounded and clamped to plus or minus one
// an item moves on at an edge where valid is high and stall is low
// registers from acceptance to o_valid: fold register, one register
//   per cordic rotation, two multiply stages, output register
// throughput: one item per cycle while i_stall is low, set by the fully
//   pipelined cordic and multiplier stages
// each stage takes a new item when it is empty or its content moves on,
//   so bubbles close up while the receiver stalls; o_stall rises only
//   when every stage holds an item and i_stall is high
// a stalled output holds its entries unchanged
// reset (synchronous, active low) empties every stage
module axis_angle_rotation_matrix (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  aarm_pkg::t_angle i_angle,
    input  aarm_pkg::t_u     i_axis_x,
    input  aarm_pkg::t_u     i_axis_y,
    input  aarm_pkg::t_u     i_axis_z,
    output logic             o_valid,
    input  logic             i_stall,
    output aarm_pkg::t_o     o_r00,
    output aarm_pkg::t_o     o_r01,
    output aarm_pkg::t_o     o_r02,
    output aarm_pkg::t_o     o_r10,
    output aarm_pkg::t_o     o_r11,
    output aarm_pkg::t_o     o_r12,
    output aarm_pkg::t_o     o_r20,
    output aarm_pkg::t_o     o_r21,
    output aarm_pkg::t_o     o_r22
);
    import aarm_pkg::*;

    logic    c_valid [N_STAGES+1];
    logic    c_ready [N_STAGES+1];
    t_cordic c_data  [N_STAGES+1];
    logic    in_ready;
    logic    m_valid;
    logic    m_ready;
    t_prod   m_data;
    t_o      res [N_OUT];

    // angle fold and cordic seed
    aarm_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (in_ready),
        .i_angle  (i_angle),
        .i_axis_x (i_axis_x),
        .i_axis_y (i_axis_y),
        .i_axis_z (i_axis_z),
        .o_valid  (c_valid[0]),
        .i_ready  (c_ready[0]),
        .o_data   (c_data[0])
    );

    assign o_stall = !in_ready;

    // one register stage per rotation
    for (genvar g = 0; g < N_STAGES; g++) begin : g_cordic
        aarm_cordic_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (SH_W'(g)),
            .i_valid (c_valid[g]),
            .o_ready (c_ready[g]),
            .i_data  (c_data[g]),
            .o_valid (c_valid[g+1]),
            .i_ready (c_ready[g+1]),
            .o_data  (c_data[g+1])
        );
    end

    // trig terms and products
    aarm_mult u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (c_valid[N_STAGES]),
        .o_ready (c_ready[N_STAGES]),
        .i_data  (c_data[N_STAGES]),
        .o_valid (m_valid),
        .i_ready (m_ready),
        .o_data  (m_data)
    );

    // entry sums and output register
    aarm_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m_valid),
        .o_ready (m_ready),
        .i_data  (m_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_r     (res)
    );

    assign o_r00 = res[0];
    assign o_r01 = res[1];
    assign o_r02 = res[2];
    assign o_r10 = res[3];
    assign o_r11 = res[4];
    assign o_r12 = res[5];
    assign o_r20 = res[6];
    assign o_r21 = res[7];
    assign o_r22 = res[8];
endmodule

// ===== rtl/core/aarm_checker.sv =====
`timescale 1ns / 1ps
`include "axis_angle_rotation_matrix_assert.svh"
module aarm_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic signed [15:0]  o_r00,
    input logic signed [15:0]  o_r11,
    input logic signed [15:0]  o_r22
);
    // reset empties the pipeline
    `AARM_ASSERT_NEXT_ALL(a_reset_empty, i_clk, !i_rst_n, !o_valid)

    // input backpressure only comes from a full pipe behind a stalled output
    `AARM_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall)

    // a stalled item stays
    `AARM_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // a stalled item keeps its diagonal
    `AARM_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, o_valid && i_stall,
        $stable(o_r00) && $stable(o_r11) && $stable(o_r22))
endmodule

bind axis_angle_rotation_matrix aarm_checker u_aarm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_r00   (o_r00),
    .o_r11   (o_r11),
    .o_r22   (o_r22)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import aarm_pkg::*;

    localparam int LATENCY     = CORDIC_STAGES + 4;
    localparam int N_RANDOM    = 1750;
    localparam int STALL_LIMIT = 20000;

    // one rotation matrix, row by row
    typedef struct packed {
        t_o r00; t_o r01; t_o r02;
        t_o r10; t_o r11; t_o r12;
        t_o r20; t_o r21; t_o r22;
    } t_matrix;

    // one directed row: inputs and, where obvious, the expected matrix
    typedef struct {
        int      angle;
        int      ax;
        int      ay;
        int      az;
        bit      typed;
        t_matrix want;
    } t_dir_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    i_valid;
    logic    o_stall;
    t_angle  i_angle;
    t_u      i_axis_x;
    t_u      i_axis_y;
    t_u      i_axis_z;
    logic    o_valid;
    logic    i_stall;
    wire t_matrix got;

    t_matrix pending_matrices[$];
    int      mismatch_count;
    int      idle_cycles;
    int      send_idle_pct;
    int      recv_idle_pct;
    bit      timed_out;

    axis_angle_rotation_matrix dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_angle  (i_angle),
        .i_axis_x (i_axis_x),
        .i_axis_y (i_axis_y),
        .i_axis_z (i_axis_z),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_r00    (got.r00),
        .o_r01    (got.r01),
        .o_r02    (got.r02),
        .o_r10    (got.r10),
        .o_r11    (got.r11),
        .o_r12    (got.r12),
        .o_r20    (got.r20),
        .o_r21    (got.r21),
        .o_r22    (got.r22)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor shift of a 64-bit signed value
    function automatic longint floor_shr(input longint v, input int sh);
        return v >>> sh;
    endfunction

    // round q.58 to q.14 and clamp to plus or minus one
    function automatic t_o q58_to_entry(input longint v);
        longint r;
        r = floor_shr(v + (64'sd1 <<< 43), 44);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return t_o'(r);
    endfunction

    // rodrigues rotation matrix with cordic sine and cosine
    function automatic t_matrix rotation_matrix(input t_angle a, input t_u ux_in,
                                                input t_u uy_in, input t_u uz_in);
        longint  z, x, y, dx, dy, c, s, t, ux, uy, uz;
        longint  c58, sx, sy, sz, xy, xz, yz;
        bit      flip;
        t_matrix m;
        z  = longint'(a) * 65536;
        ux = ux_in;
        uy = uy_in;
        uz = uz_in;
        flip = 1'b0;
        x = 652032874;
        y = 0;
        // fold into plus or minus half pi
        if (z > 421657428) begin
            z -= 843314857;
            flip = 1'b1;
        end else if (z < -421657428) begin
            z += 843314857;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_Q28[i]);
            end else begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_Q28[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        t = 64'sd1073741824 - c;
        c58 = c * (64'sd1 <<< 28);
        sx = ux * s * 16384;
        sy = uy * s * 16384;
        sz = uz * s * 16384;
        xy = ux * uy * t;
        xz = ux * uz * t;
        yz = uy * uz * t;
        m.r00 = q58_to_entry(c58 + ux * ux * t);
        m.r01 = q58_to_entry(xy - sz);
        m.r02 = q58_to_entry(xz + sy);
        m.r10 = q58_to_entry(xy + sz);
        m.r11 = q58_to_entry(c58 + uy * uy * t);
        m.r12 = q58_to_entry(yz - sx);
        m.r20 = q58_to_entry(xz - sy);
        m.r21 = q58_to_entry(yz + sx);
        m.r22 = q58_to_entry(c58 + uz * uz * t);
        return m;
    endfunction

    // send one item, idling at random first
    task automatic send_item(input int a, input int ax, input int ay, input int az,
                             input bit typed, input t_matrix want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_angle  <= t_angle'(a);
        i_axis_x <= t_u'(ax);
        i_axis_y <= t_u'(ay);
        i_axis_z <= t_u'(az);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (typed) pending_matrices.push_back(want);
        else pending_matrices.push_back(rotation_matrix(t_angle'(a), t_u'(ax),
                                                        t_u'(ay), t_u'(az)));
        @(negedge i_clk);
    endtask

    // random axis: mostly near unit length, sometimes arbitrary
    task automatic send_random;
        int a, ax, ay, az, mode;
        real th, ph;
        mode = $urandom_range(9);
        a = $urandom_range(25736) - 12868;
        if (mode == 0) a = $signed(15'($urandom()));
        if (mode <= 1) begin
            ax = $signed(16'($urandom()));
            ay = $signed(16'($urandom()));
            az = $signed(16'($urandom()));
        end else begin
            th = $urandom_range(62831) / 10000.0;
            ph = $urandom_range(31415) / 10000.0;
            ax = $rtoi(16384.0 * $sin(ph) * $cos(th));
            ay = $rtoi(16384.0 * $sin(ph) * $sin(th));
            az = $rtoi(16384.0 * $cos(ph));
        end
        send_item(a, ax, ay, az, 1'b0, '0);
    endtask

    // receiver stall and result check
    always @(negedge i_clk) begin
        if (i_rst_n) i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_matrices.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected matrix %h", got);
            end else begin
                t_matrix want;
                want = pending_matrices.pop_front();
                if (want !== got) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("matrix mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Test completed with failures");
            $finish;
        end
    end

    t_dir_row dir_rows[$];

    initial begin
        t_matrix all_hi;
        int      wait_cycles;
        all_hi  = '{16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384};
        i_valid  = 1'b0;
        i_stall  = 1'b0;
        i_angle  = '0;
        i_axis_x = '0;
        i_axis_y = '0;
        i_axis_z = '0;
        i_rst_n  = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        timed_out      = 1'b0;
        send_idle_pct  = 12;
        recv_idle_pct  = 65;
        // zero angle about each axis, identity up to the cordic residue
        dir_rows.push_back('{0, 16384, 0, 0, 1'b0, '0});
        dir_rows.push_back('{0, 0, 16384, 0, 1'b0, '0});
        dir_rows.push_back('{0, 0, 0, 16384, 1'b0, '0});
        // most negative axis saturates every entry high at pi
        dir_rows.push_back('{12868, -32768, -32768, -32768, 1'b1, all_hi});
        // field extremes and angles around the fold
        dir_rows.push_back('{12868, 0, 0, 16384, 1'b0, '0});
        dir_rows.push_back('{-12868, 16384, 0, 0, 1'b0, '0});
        dir_rows.push_back('{6433, 0, 16384, 0, 1'b0, '0});
        dir_rows.push_back('{6434, 0, 16384, 0, 1'b0, '0});
        dir_rows.push_back('{-6433, 0, 0, -16384, 1'b0, '0});
        dir_rows.push_back('{-6434, 0, 0, -16384, 1'b0, '0});
        dir_rows.push_back('{16383, 9459, 9459, 9459, 1'b0, '0});
        dir_rows.push_back('{-16384, 9459, -9459, 9459, 1'b0, '0});
        // axis not of unit length
        dir_rows.push_back('{3000, 32767, 32767, 32767, 1'b0, '0});
        dir_rows.push_back('{-3000, -32768, 32767, -1, 1'b0, '0});
        dir_rows.push_back('{1, -1, 1, -1, 1'b0, '0});
        dir_rows.push_back('{-1, 0, 0, 0, 1'b0, '0});
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (dir_rows[k])
            send_item(dir_rows[k].angle, dir_rows[k].ax, dir_rows[k].ay, dir_rows[k].az,
                      dir_rows[k].typed, dir_rows[k].want);
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) begin
                send_idle_pct = 65;
                recv_idle_pct = 12;
            end else if (n == 2 * N_RANDOM / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_random();
        end
        i_valid <= 1'b0;
        while (pending_matrices.size() != 0) @(posedge i_clk);
        wait_cycles = 0;
        while (wait_cycles < 2 * LATENCY) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (mismatch_count == 0 && pending_matrices.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
